@@ rtl/brl_pkg.sv @@
// ----------------------------------------------------------------------------
// brl_pkg
// shared codes, defaults and types for the line rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

  // default coordinate width
  localparam int unsigned COORD_BITS_DEF = 12;

  // action codes of an input beat
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // line walker phase
  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_SECOND   = 3'b010,
    PH_INTERIOR = 3'b100
  } phase_t;

  // octant folding flags of the current line
  typedef struct packed {
    logic swapped;
    logic mirrored;
  } fold_flags_t;

endpackage

`default_nettype wire

@@ rtl/brl_in_if.sv @@
// ----------------------------------------------------------------------------
// brl_in_if
// command channel: start a line or step to the next pixel
// ----------------------------------------------------------------------------
`default_nettype none

interface brl_in_if #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, action, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, action, x_start, y_start, x_end, y_end, output ready);
endinterface

`default_nettype wire

@@ rtl/brl_out_if.sv @@
// ----------------------------------------------------------------------------
// brl_out_if
// pixel channel: one result per command beat
// ----------------------------------------------------------------------------
`default_nettype none

interface brl_out_if #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  pixel_valid;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

`default_nettype wire

@@ rtl/bresenham_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core
// all-octant line rasterizer, one result per command beat
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  --------------------------------------------
//  in_ch    in   valid / ready  action, x_start, y_start, x_end, y_end
//  out_ch   out  valid / ready  pixel_valid, pixel_x, pixel_y, last_pixel
//
//  one beat per clock sustained while out_ch does not stall; a beat waits in the input register,
//  its result is captured in the result register when the beat advances,
//  and it leaves from there on out_ch
//  the per-beat path is the setup fold on a start or one add and compare on a step
//  synchronous active-low reset clears the phase and both valid flags
//  a stalled out_ch holds its result; in_ch keeps taking a beat while its
//  input register is empty or drains into the result register this cycle
//
`default_nettype none

module bresenham_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  brl_in_if.sink   in_ch,
  brl_out_if.source out_ch
);
  import brl_pkg::*;

  // input register stage
  logic                  s0_valid_r, s0_valid_nxt;
  logic                  s0_action_r;
  logic [COORD_BITS-1:0] s0_xs_r, s0_ys_r, s0_xe_r, s0_ye_r;

  // result register stage
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_pv_r, out_last_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;

  // engine result for the beat in the input register
  logic                  eng_pv, eng_last;
  logic [COORD_BITS-1:0] eng_x, eng_y;

  logic                  advance, in_take;

  // a beat moves on when the result register is free or being drained
  assign advance     = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  brl_engine #(.COORD_BITS(COORD_BITS)) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .ena             (advance),
    .action          (s0_action_r),
    .x_start         (s0_xs_r),
    .y_start         (s0_ys_r),
    .x_end           (s0_xe_r),
    .y_end           (s0_ye_r),
    .res_pixel_valid (eng_pv),
    .res_pixel_x     (eng_x),
    .res_pixel_y     (eng_y),
    .res_last_pixel  (eng_last)
  );

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_take) begin
      s0_valid_nxt = 1'b1;
    end else if (advance) begin
      s0_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the command beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_action_r <= in_ch.action;
      s0_xs_r     <= in_ch.x_start;
      s0_ys_r     <= in_ch.y_start;
      s0_xe_r     <= in_ch.x_end;
      s0_ye_r     <= in_ch.y_end;
    end
  end

  // capture the pixel result
  always_ff @(posedge clk) begin
    if (advance) begin
      out_pv_r   <= eng_pv;
      out_x_r    <= eng_x;
      out_y_r    <= eng_y;
      out_last_r <= eng_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_valid = out_pv_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.last_pixel  = out_last_r;

  // a start beat always yields the first endpoint, never flagged last
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s0_action_r == ACT_START) |=> out_valid_r && out_pv_r && !out_last_r)
    else $error("start beat gave a wrong result");

  // an idle step carries an all-zero pixel
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pv_r |-> (out_x_r == '0) && (out_y_r == '0) && !out_last_r)
    else $error("idle step result not cleared");

  // a held beat in the input register is not lost while the output stalls
  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && !advance |=> s0_valid_r && $stable(s0_action_r) && $stable(s0_xs_r))
    else $error("stalled command beat changed");

endmodule

`default_nettype wire

@@ rtl/brl_setup.sv @@
// ----------------------------------------------------------------------------
// brl_setup
// folds a line into the first octant and derives the midpoint increments
// ----------------------------------------------------------------------------
`default_nettype none

module brl_setup #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  wire logic [COORD_BITS-1:0]          ax,
  input  wire logic [COORD_BITS-1:0]          ay,
  input  wire logic [COORD_BITS-1:0]          bx,
  input  wire logic [COORD_BITS-1:0]          by,
  output      logic signed [COORD_BITS:0]     major,
  output      logic signed [COORD_BITS:0]     minor,
  output      logic signed [COORD_BITS:0]     limit,
  output      logic signed [COORD_BITS+2:0]   decision,
  output      logic signed [COORD_BITS+1:0]   inc_straight,
  output      logic signed [COORD_BITS+1:0]   inc_diagonal,
  output      brl_pkg::fold_flags_t           flags
);
  import brl_pkg::*;

  localparam int unsigned W  = COORD_BITS + 1;
  localparam int unsigned IW = COORD_BITS + 2;
  localparam int unsigned DW = COORD_BITS + 3;

  logic signed [W-1:0]  ax_s, ay_s, bx_s, by_s;
  logic signed [W-1:0]  dx, dy, dy_m, ay_m, by_m;
  logic signed [W-1:0]  adx, ady;
  logic signed [W-1:0]  a_maj, a_min, b_maj, b_min, d_maj, d_min;
  logic signed [W-1:0]  dmaj, dmin;
  logic signed [IW-1:0] two_dmin, two_dmaj;
  logic                 mirror, swap, reorder;

  always_comb begin
    ax_s = $signed({1'b0, ax});
    ay_s = $signed({1'b0, ay});
    bx_s = $signed({1'b0, bx});
    by_s = $signed({1'b0, by});
    dx   = bx_s - ax_s;
    dy   = by_s - ay_s;

    // mirror y when dx and dy have opposite signs
    mirror = ((dx < 0) && (dy > 0)) || ((dx > 0) && (dy < 0));
    ay_m   = mirror ? -ay_s : ay_s;
    by_m   = mirror ? -by_s : by_s;
    dy_m   = mirror ? -dy : dy;

    adx  = (dx < 0) ? -dx : dx;
    ady  = (dy_m < 0) ? -dy_m : dy_m;
    swap = adx < ady;

    a_maj = swap ? ay_m : ax_s;
    a_min = swap ? ax_s : ay_m;
    b_maj = swap ? by_m : bx_s;
    b_min = swap ? bx_s : by_m;
    d_maj = swap ? dy_m : dx;
    d_min = swap ? dx : dy_m;

    // walk from the low end of the major axis
    reorder = a_maj > b_maj;
    major   = reorder ? b_maj : a_maj;
    minor   = reorder ? b_min : a_min;
    limit   = reorder ? a_maj : b_maj;
    dmaj    = reorder ? -d_maj : d_maj;
    dmin    = reorder ? -d_min : d_min;

    two_dmin     = {dmin, 1'b0};
    two_dmaj     = {dmaj, 1'b0};
    inc_straight = two_dmin;
    inc_diagonal = two_dmin - two_dmaj;
    decision     = $signed({two_dmin[IW-1], two_dmin})
                 - $signed({{(DW-W){dmaj[W-1]}}, dmaj});

    flags.swapped  = swap;
    flags.mirrored = mirror;
  end

endmodule

`default_nettype wire

@@ rtl/brl_engine.sv @@
// ----------------------------------------------------------------------------
// brl_engine
// line state and one midpoint step per beat, result is combinational
// ----------------------------------------------------------------------------
`default_nettype none

module brl_engine #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  ena,
  input  wire logic                  action,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  output      logic                  res_pixel_valid,
  output      logic [COORD_BITS-1:0] res_pixel_x,
  output      logic [COORD_BITS-1:0] res_pixel_y,
  output      logic                  res_last_pixel
);
  import brl_pkg::*;

  localparam int unsigned W  = COORD_BITS + 1;
  localparam int unsigned IW = COORD_BITS + 2;
  localparam int unsigned DW = COORD_BITS + 3;

  phase_t                phase_r, phase_nxt;
  logic signed [W-1:0]   major_r, major_nxt;
  logic signed [W-1:0]   minor_r, minor_nxt;
  logic signed [W-1:0]   limit_r, limit_nxt;
  logic signed [DW-1:0]  dec_r, dec_nxt;
  logic signed [IW-1:0]  inc_s_r, inc_s_nxt;
  logic signed [IW-1:0]  inc_d_r, inc_d_nxt;
  fold_flags_t           flags_r, flags_nxt;
  logic [COORD_BITS-1:0] sec_x_r, sec_x_nxt;
  logic [COORD_BITS-1:0] sec_y_r, sec_y_nxt;

  logic signed [W-1:0]   su_major, su_minor, su_limit;
  logic signed [DW-1:0]  su_dec;
  logic signed [IW-1:0]  su_inc_s, su_inc_d;
  fold_flags_t           su_flags;

  logic signed [W-1:0]   maj1, min1, px, py_f, py;
  logic signed [W:0]     span;
  logic                  dec_le0, last_second, last_interior;

  brl_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .ax           (x_start),
    .ay           (y_start),
    .bx           (x_end),
    .by           (y_end),
    .major        (su_major),
    .minor        (su_minor),
    .limit        (su_limit),
    .decision     (su_dec),
    .inc_straight (su_inc_s),
    .inc_diagonal (su_inc_d),
    .flags        (su_flags)
  );

  // next interior pixel in folded space
  always_comb begin
    maj1          = major_r + W'(1);
    dec_le0       = dec_r[DW-1] || (dec_r == '0);
    min1          = dec_le0 ? minor_r : (minor_r + W'(1));
    px            = flags_r.swapped ? min1 : maj1;
    py_f          = flags_r.swapped ? maj1 : min1;
    py            = flags_r.mirrored ? -py_f : py_f;
    span          = $signed({limit_r[W-1], limit_r}) - $signed({major_r[W-1], major_r});
    last_second   = span < 2;
    last_interior = ($signed({maj1[W-1], maj1}) + 2'sd1) >= $signed({limit_r[W-1], limit_r});
  end

  always_comb begin
    phase_nxt       = phase_r;
    major_nxt       = major_r;
    minor_nxt       = minor_r;
    limit_nxt       = limit_r;
    dec_nxt         = dec_r;
    inc_s_nxt       = inc_s_r;
    inc_d_nxt       = inc_d_r;
    flags_nxt       = flags_r;
    sec_x_nxt       = sec_x_r;
    sec_y_nxt       = sec_y_r;
    res_pixel_valid = 1'b0;
    res_pixel_x     = '0;
    res_pixel_y     = '0;
    res_last_pixel  = 1'b0;

    if (action == ACT_START) begin
      // a start aborts whatever line is in flight
      res_pixel_valid = 1'b1;
      res_pixel_x     = x_start;
      res_pixel_y     = y_start;
      phase_nxt       = PH_SECOND;
      major_nxt       = su_major;
      minor_nxt       = su_minor;
      limit_nxt       = su_limit;
      dec_nxt         = su_dec;
      inc_s_nxt       = su_inc_s;
      inc_d_nxt       = su_inc_d;
      flags_nxt       = su_flags;
      sec_x_nxt       = x_end;
      sec_y_nxt       = y_end;
    end else begin
      unique case (phase_r)
        PH_SECOND: begin
          res_pixel_valid = 1'b1;
          res_pixel_x     = sec_x_r;
          res_pixel_y     = sec_y_r;
          res_last_pixel  = last_second;
          phase_nxt       = last_second ? PH_IDLE : PH_INTERIOR;
        end
        PH_INTERIOR: begin
          res_pixel_valid = 1'b1;
          res_pixel_x     = px[COORD_BITS-1:0];
          res_pixel_y     = py[COORD_BITS-1:0];
          res_last_pixel  = last_interior;
          major_nxt       = maj1;
          minor_nxt       = min1;
          dec_nxt         = dec_r + (dec_le0 ? $signed({inc_s_r[IW-1], inc_s_r})
                                             : $signed({inc_d_r[IW-1], inc_d_r}));
          if (last_interior) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (ena) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      limit_r <= limit_nxt;
      dec_r   <= dec_nxt;
      inc_s_r <= inc_s_nxt;
      inc_d_r <= inc_d_nxt;
      flags_r <= flags_nxt;
      sec_x_r <= sec_x_nxt;
      sec_y_r <= sec_y_nxt;
    end
  end

  // a step while idle leaves the walker idle
  a_idle_step_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ena && (action == ACT_STEP) && (phase_r == PH_IDLE) |=> phase_r == PH_IDLE)
    else $error("idle step left the idle phase");

  // every start arms the second endpoint
  a_start_arms_second: assert property (@(posedge clk) disable iff (!rst_n)
    ena && (action == ACT_START) |=> phase_r == PH_SECOND)
    else $error("start did not arm the second endpoint");

  // interior walk never passes the far endpoint
  a_interior_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_INTERIOR) |-> $signed(major_r) < $signed(limit_r))
    else $error("interior walk reached the far endpoint");

endmodule

`default_nettype wire
